@@ rtl/core/assert_macros.svh @@
// assertion helpers used by the histogram core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ rtl/core/fcfh_pkg.sv @@
package fcfh_pkg;

  // default sizing
  localparam int unsigned SYMBOLS_DEF     = 128;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CODE_W    = 7;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned FREQ_W    = FRAC_BITS + 1;
  localparam int unsigned MASK_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = MASK_W;

  // action codes
  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CASE_SENS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HI   = 2'd2;

  // case folding
  localparam logic [CODE_W-1:0] UPPER_FIRST = 7'd65;
  localparam logic [CODE_W-1:0] UPPER_LAST  = 7'd90;
  localparam logic [CODE_W-1:0] CASE_OFFSET = 7'd32;
  localparam logic [CODE_W-1:0] LOWER_FIRST = UPPER_FIRST + CASE_OFFSET;
  localparam logic [CODE_W-1:0] LOWER_LAST  = UPPER_LAST + CASE_OFFSET;

  // Q1.16 value of 1.0
  localparam logic [FREQ_W-1:0] FREQ_ONE = 17'h10000;

  // divider status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/fcfh_if.sv @@
// input word channel
interface fcfh_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [fcfh_pkg::BYTE_W-1:0]      byte_value;
  logic [fcfh_pkg::CODE_W-1:0]      read_index;

  modport source (output valid, action, byte_value, read_index, input ready);
  modport sink   (input valid, action, byte_value, read_index, output ready);
endinterface

// result word channel
interface fcfh_out_if;
  logic                             valid;
  logic                             ready;
  logic [fcfh_pkg::OUT_W-1:0]       entry_count;
  logic [fcfh_pkg::OUT_W-1:0]       kept_total;
  logic [fcfh_pkg::FREQ_W-1:0]      frequency;
  logic                             frequency_valid;

  modport source (output valid, entry_count, kept_total, frequency, frequency_valid,
                  input ready);
  modport sink   (input valid, entry_count, kept_total, frequency, frequency_valid,
                  output ready);
endinterface

@@ rtl/core/fcfh_div.sv @@
// restoring divider: quot = floor(num * 2^16 / den), one quotient bit per cycle
module fcfh_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          ack_i,
  input  logic [fcfh_pkg::OUT_W-1:0]    num_i,
  input  logic [fcfh_pkg::OUT_W-1:0]    den_i,
  output fcfh_pkg::div_stat_t           stat_o,
  output logic [fcfh_pkg::FREQ_W-1:0]   quot_o
);

  localparam int unsigned StepW = $clog2(fcfh_pkg::FREQ_W);
  localparam logic [StepW-1:0] LastStep = StepW'(fcfh_pkg::FREQ_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e                        state_q;
  logic [StepW-1:0]              step_q;
  logic [fcfh_pkg::OUT_W:0]      rem_q;
  logic [fcfh_pkg::OUT_W-1:0]    den_q;
  logic [fcfh_pkg::FREQ_W-1:0]   quot_q;

  logic [fcfh_pkg::OUT_W:0]      trial;
  logic                          take;
  logic [fcfh_pkg::OUT_W:0]      rem_d;

  // first step compares the numerator itself, later steps shift in a zero
  always_comb begin
    trial = (step_q == '0) ? rem_q : {rem_q[fcfh_pkg::OUT_W-1:0], 1'b0};
    take  = (trial >= {1'b0, den_q});
    rem_d = take ? (trial - {1'b0, den_q}) : trial;
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      rem_q   <= '0;
      den_q   <= '0;
      quot_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            rem_q   <= {1'b0, num_i};
            den_q   <= den_i;
            quot_q  <= '0;
            step_q  <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          rem_q  <= rem_d;
          quot_q <= {quot_q[fcfh_pkg::FREQ_W-2:0], take};
          if (step_q == LastStep) begin
            state_q <= S_DONE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign quot_o      = quot_q;

endmodule

@@ rtl/core/filtered_char_frequency_histogram_core.sv @@
// Character frequency histogram. Count words (action 0) are taken one per cycle
// back to back while no read word is in progress: the entry is read from the
// count memory in the accept cycle and written back in the cycle after, with the
// last write forwarded when the next word hits the same code. A read word
// (action 1) holds the next word off through the memory read, the bit-serial
// Q1.16 divider (one quotient bit per cycle) and the handoff into the output
// register once it is free; the result waits there while count words flow.
// Counts are cleared at reset through per-entry valid bits; no clearing pass.
`include "assert_macros.svh"

module filtered_char_frequency_histogram_core #(
  parameter int unsigned SYMBOLS     = fcfh_pkg::SYMBOLS_DEF,
  parameter int unsigned COUNT_WIDTH = fcfh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fcfh_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fcfh_pkg::CFG_W-1:0]        cfg_data_i,
  fcfh_in_if.sink                           in_i,
  fcfh_out_if.source                        out_o
);

  localparam int unsigned AddrW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam logic [fcfh_pkg::BYTE_W-1:0] SymLimit = fcfh_pkg::BYTE_W'(SYMBOLS);

  // configuration registers
  logic                        case_sens_q;
  logic [fcfh_pkg::MASK_W-1:0] mask_lo_q;
  logic [fcfh_pkg::MASK_W-1:0] mask_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_sens_q <= 1'b0;
      mask_lo_q   <= '1;
      mask_hi_q   <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcfh_pkg::REG_CASE_SENS: case_sens_q <= cfg_data_i[0];
        fcfh_pkg::REG_MASK_LO:   mask_lo_q   <= cfg_data_i;
        fcfh_pkg::REG_MASK_HI:   mask_hi_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // accept side: fold, range check and alphabet filter
  logic                             in_ready;
  logic                             in_fire;
  logic                             is_read;
  logic [fcfh_pkg::CODE_W-1:0]      code;
  logic [2*fcfh_pkg::MASK_W-1:0]    mask_all;
  logic                             keep;
  logic                             idx_ok;
  logic [AddrW-1:0]                 rd_addr;

  assign in_fire = in_i.valid && in_ready;
  assign is_read = (in_i.action == fcfh_pkg::ACT_READ);
  assign mask_all = {mask_hi_q, mask_lo_q};

  always_comb begin
    code = in_i.byte_value[fcfh_pkg::CODE_W-1:0];
    if (!case_sens_q && (code inside {[fcfh_pkg::LOWER_FIRST:fcfh_pkg::LOWER_LAST]})) begin
      code = code - fcfh_pkg::CASE_OFFSET;
    end
    keep    = (in_i.byte_value < SymLimit) && mask_all[code];
    idx_ok  = ({1'b0, in_i.read_index} < SymLimit);
    rd_addr = is_read ? in_i.read_index[AddrW-1:0] : code[AddrW-1:0];
  end

  // count memory with registered read
  logic [COUNT_WIDTH-1:0] mem_q [SYMBOLS];
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic [SYMBOLS-1:0]     entry_vld_q;

  // stage one: read data back, increment and write
  logic                   s1_cnt_q;
  logic                   s1_rd_q;
  logic [AddrW-1:0]       s1_addr_q;
  logic                   s1_idx_ok_q;
  logic                   fwd_vld_q;
  logic [AddrW-1:0]       fwd_addr_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;
  logic [COUNT_WIDTH-1:0] total_q;
  logic [COUNT_WIDTH-1:0] old_cnt;
  logic [COUNT_WIDTH-1:0] new_cnt;
  logic [COUNT_WIDTH-1:0] cnt_raw;

  always_comb begin
    if (fwd_vld_q && (fwd_addr_q == s1_addr_q)) begin
      old_cnt = fwd_data_q;
    end else if (entry_vld_q[s1_addr_q]) begin
      old_cnt = rdata_q;
    end else begin
      old_cnt = '0;
    end
    new_cnt = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
    cnt_raw = s1_idx_ok_q ? old_cnt : '0;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (s1_cnt_q) begin
      mem_q[s1_addr_q] <= new_cnt;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q   <= rd_addr;
      s1_idx_ok_q <= idx_ok;
    end
    if (s1_cnt_q) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_cnt;
    end
  end

  // pipeline control, valid bits and total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_cnt_q    <= 1'b0;
      s1_rd_q     <= 1'b0;
      fwd_vld_q   <= 1'b0;
      entry_vld_q <= '0;
      total_q     <= '0;
    end else begin
      s1_cnt_q  <= in_fire && !is_read && keep;
      s1_rd_q   <= in_fire && is_read;
      fwd_vld_q <= s1_cnt_q;
      if (s1_cnt_q) begin
        entry_vld_q[s1_addr_q] <= 1'b1;
        if (!(&total_q)) begin
          total_q <= total_q + 1'b1;
        end
      end
    end
  end

  // cap count and total at the 32-bit report width, and the count at the total
  logic [fcfh_pkg::OUT_W-1:0] cnt32;
  logic [fcfh_pkg::OUT_W-1:0] tot32;
  logic [fcfh_pkg::OUT_W-1:0] cnt_cap;

  if (COUNT_WIDTH > fcfh_pkg::OUT_W) begin : g_cap
    assign cnt32 = (|cnt_raw[COUNT_WIDTH-1:fcfh_pkg::OUT_W]) ? '1
                                                              : cnt_raw[fcfh_pkg::OUT_W-1:0];
    assign tot32 = (|total_q[COUNT_WIDTH-1:fcfh_pkg::OUT_W]) ? '1
                                                              : total_q[fcfh_pkg::OUT_W-1:0];
  end else begin : g_ext
    assign cnt32 = fcfh_pkg::OUT_W'(cnt_raw);
    assign tot32 = fcfh_pkg::OUT_W'(total_q);
  end

  assign cnt_cap = (cnt32 > tot32) ? tot32 : cnt32;

  // frequency divider
  fcfh_pkg::div_stat_t          div_stat;
  logic [fcfh_pkg::FREQ_W-1:0]  quot;
  logic                         out_load;
  logic [fcfh_pkg::OUT_W-1:0]   res_cnt_q;
  logic [fcfh_pkg::OUT_W-1:0]   res_tot_q;

  fcfh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(s1_rd_q),
    .ack_i  (out_load),
    .num_i  (cnt_cap),
    .den_i  (tot32),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i) begin
    if (s1_rd_q) begin
      res_cnt_q <= cnt_cap;
      res_tot_q <= tot32;
    end
  end

  // a read holds the input until its result is in the output register
  assign in_ready   = !s1_rd_q && !div_stat.busy;
  assign in_i.ready = in_ready;

  // output register
  logic                         out_vld_q;
  logic [fcfh_pkg::OUT_W-1:0]   out_cnt_q;
  logic [fcfh_pkg::OUT_W-1:0]   out_tot_q;
  logic [fcfh_pkg::FREQ_W-1:0]  out_freq_q;
  logic                         out_fvld_q;

  assign out_load = div_stat.done && (!out_vld_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cnt_q  <= res_cnt_q;
      out_tot_q  <= res_tot_q;
      out_freq_q <= (res_tot_q == '0) ? '0 : quot;
      out_fvld_q <= (res_tot_q != '0);
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.entry_count     = out_cnt_q;
  assign out_o.kept_total      = out_tot_q;
  assign out_o.frequency       = out_freq_q;
  assign out_o.frequency_valid = out_fvld_q;

  // checks
  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, div_stat.busy, !in_ready, "word taken while dividing")
  `ASSERT_IMPL(a_start_idle, clk_i, rst_ni, s1_rd_q, !div_stat.busy, "divider started while busy")
  `ASSERT_IMPL(a_freq_range, clk_i, rst_ni, out_vld_q, out_freq_q <= fcfh_pkg::FREQ_ONE, "frequency above one")
  `ASSERT_NEXT(a_read_stage, clk_i, rst_ni, in_fire && is_read, s1_rd_q && !s1_cnt_q, "read word lost")

endmodule
